[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants for the double-ended queue: operation and status
// codes, controller states, and the controller to datapath command bundle
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int REQ_W    = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ADDR_FRONT_PUSH = 2'd0,
      ADDR_BACK_PUSH  = 2'd1,
      ADDR_HEAD       = 2'd2,
      ADDR_TAIL       = 2'd3
   } addr_sel_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic         mem_wr;
      logic         mem_rd;
      addr_sel_type addr_sel;
      logic         head_dec;
      logic         head_inc;
      logic         count_inc;
      logic         count_dec;
      logic         rsp_load;
      logic         rsp_from_mem;
      status_type   rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_full;
      logic is_zero;
      logic rsp_free;
   } dp_status_type;

endpackage

[hdl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// controller: decodes each operation, checks full and empty, and sequences
// the ram read for pops and peeks
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [MODE_W-1:0] mode,
   input  dp_status_type     dp_status,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = dp_status.rsp_free;
            if (req_tvalid && dp_status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               case (mode)
                  MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                     if (dp_status.is_full) begin
                        cmd.rsp_status = STATUS_FULL;
                     end else begin
                        cmd.mem_wr    = 1'b1;
                        cmd.count_inc = 1'b1;
                        if (mode == MODE_PUSH_FRONT) begin
                           cmd.addr_sel = ADDR_FRONT_PUSH;
                           cmd.head_dec = 1'b1;
                        end else begin
                           cmd.addr_sel = ADDR_BACK_PUSH;
                        end
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                     if (dp_status.is_zero) begin
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.rsp_load = 1'b0;
                        cmd.mem_rd   = 1'b1;
                        state_in     = ST_READ;
                        if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
                           cmd.addr_sel = ADDR_HEAD;
                        end else begin
                           cmd.addr_sel = ADDR_TAIL;
                        end
                        cmd.head_inc  = (mode == MODE_POP_FRONT);
                        cmd.count_dec = (mode == MODE_POP_FRONT || mode == MODE_POP_BACK);
                     end
                  end
                  default: begin
                     cmd.rsp_status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_mem = 1'b1;
            cmd.rsp_status   = STATUS_OK;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/deq_datapath.sv]
// ----------------------------------------------------------------------------
// deq_datapath
// head pointer, entry count, ring address arithmetic, slot ram and the
// result register
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH  = 256,
   localparam int AW    = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [VALUE_W-1:0]  push_value,
   input  logic                rsp_tready,
   output dp_status_type       dp_status,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  out_value,
   output logic [STATUS_W-1:0] status,
   output logic [CNT_W-1:0]    entry_count,
   output logic                is_empty
);

   localparam int SUM_W = AW + 1;

   logic [AW-1:0]       head_ff;
   logic [AW-1:0]       head_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_empty_ff;

   logic [AW-1:0]       head_next;
   logic [AW-1:0]       head_prev;
   logic [AW-1:0]       back_pos;
   logic [AW-1:0]       tail_pos;
   logic [AW-1:0]       addr;
   logic [CNT_W-1:0]    count_m1;
   logic [VALUE_W-1:0]  rd_data;

   function automatic logic [AW-1:0] wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] fixed;
      fixed = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
      return fixed[AW-1:0];
   endfunction

   always_comb begin
      count_m1  = count_ff - CNT_W'(1);
      head_next = wrap({1'b0, head_ff} + SUM_W'(1));
      head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      back_pos  = wrap({1'b0, head_ff} + {1'b0, count_ff[AW-1:0]});
      tail_pos  = wrap({1'b0, head_ff} + {1'b0, count_m1[AW-1:0]});
      case (cmd.addr_sel)
         ADDR_FRONT_PUSH: addr = head_prev;
         ADDR_BACK_PUSH:  addr = back_pos;
         ADDR_HEAD:       addr = head_ff;
         ADDR_TAIL:       addr = tail_pos;
         default:         addr = head_ff;
      endcase

      head_in = head_ff;
      if (cmd.head_dec) begin
         head_in = head_prev;
      end else if (cmd.head_inc) begin
         head_in = head_next;
      end

      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff  <= cmd.rsp_from_mem ? rd_data : '0;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   deq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .rd_en   (cmd.mem_rd),
      .addr    (addr),
      .wr_data (push_value),
      .rd_data (rd_data)
   );

   assign dp_status.is_full  = (count_ff == CNT_W'(DEPTH));
   assign dp_status.is_zero  = (count_ff == '0);
   assign dp_status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid   = rsp_valid_ff;
   assign out_value   = rsp_value_ff;
   assign status      = rsp_status_ff;
   assign entry_count = rsp_count_ff;
   assign is_empty    = rsp_empty_ff;

endmodule

[hdl/double_ended_queue.sv]
// timing: push, full, empty and unused-mode results are registered at accept;
// pops and peeks take the registered slot ram read first and accept no request meanwhile
// throughput: one push word per cycle while the response sink keeps up
// reset: synchronous, clears head pointer, count and result valid; slot ram is not
// cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of 32-bit values held in a ring buffer
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH  = 256,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((VALUE_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // mode, push_value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // out_value, status, entry_count, is_empty
);

   localparam int PAD_W = RSP_W - (VALUE_W + STATUS_W + CNT_W + 1);

   cmd_type             cmd;
   dp_status_type       dp_status;
   logic [VALUE_W-1:0]  out_value;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    entry_count;
   logic                is_empty;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (req_tdata[MODE_W-1:0]),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .push_value  (req_tdata[MODE_W +: VALUE_W]),
      .rsp_tready  (rsp_tready),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_tvalid),
      .out_value   (out_value),
      .status      (status),
      .entry_count (entry_count),
      .is_empty    (is_empty)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, is_empty, entry_count, status, out_value};

endmodule

[dv/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// self-checking bench for the ring-buffer deque: a queue-fed driver offers
// push, pop, peek and unused-mode words, a scoreboard predicts each result
// word and checks the response stream; phases fill the queue to full and
// drain it to empty under varying source idling and sink backpressure
// ----------------------------------------------------------------------------
module double_ended_queue_tb
   import deq_pkg::*;
();

   localparam int          SLOT_COUNT    = 256;
   localparam int          RSP_BITS      = 48;
   localparam int          WATCHDOG_MAX  = 3000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          CHUNK_ITEMS   = 30;
   localparam logic [2:0]  MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0]  MODE_UNUSED_7 = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] value;
   } deq_op_type;

   typedef struct {
      logic [31:0] value;
      status_type  status;
      logic [8:0]  count;
      logic        empty;
   } deq_result_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;    // mode, push_value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;          // out_value, status, entry_count, is_empty

   deq_op_type     pending_ops[$];
   deq_result_type expected_words[$];

   // scoreboard copy of the ring buffer
   logic [31:0] slot_copy[SLOT_COUNT];
   logic [7:0]  front_ptr  = '0;
   logic [8:0]  fill_count = '0;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_trigger   = 1'b0;
   logic hold_seen      = 1'b0;
   int   hold_left      = 0;
   logic req_fired      = 1'b0;
   int   error_count    = 0;
   int   quiet_cycles   = 0;
   int   chunk_no       = 0;

   double_ended_queue #(.DEPTH(SLOT_COUNT)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic deq_result_type apply_deq_op(logic [2:0] mode, logic [31:0] value);
      deq_result_type r;
      logic [7:0]     idx;
      r.value  = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (fill_count == SLOT_COUNT) begin
               r.status = STATUS_FULL;
            end else if (mode == MODE_PUSH_FRONT) begin
               front_ptr = front_ptr - 8'd1;
               slot_copy[front_ptr] = value;
               fill_count = fill_count + 9'd1;
            end else begin
               idx = front_ptr + fill_count[7:0];
               slot_copy[idx] = value;
               fill_count = fill_count + 9'd1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
            if (fill_count == 0) begin
               r.status = STATUS_EMPTY;
            end else if (mode == MODE_POP_FRONT || mode == MODE_PEEK_FRONT) begin
               r.value = slot_copy[front_ptr];
               if (mode == MODE_POP_FRONT) begin
                  front_ptr = front_ptr + 8'd1;
                  fill_count = fill_count - 9'd1;
               end
            end else begin
               idx = front_ptr + fill_count[7:0] - 8'd1;
               r.value = slot_copy[idx];
               if (mode == MODE_POP_BACK) fill_count = fill_count - 9'd1;
            end
         end
         default: begin
         end
      endcase
      r.count = fill_count;
      r.empty = (fill_count == 0);
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin : drive_req
      deq_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op = pending_ops[0];
            pending_ops.delete(0);
            req_tdata  <= {{(REQ_W - 35){1'b0}}, op.value, op.mode};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure, with a long hold-off on request
   always @(negedge clock) begin : drive_rsp
      if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // scoreboard
   always @(posedge clock) begin : check_rsp
      deq_result_type want;
      deq_result_type pred;
      logic [31:0]    got_value;
      logic [1:0]     got_status;
      logic [8:0]     got_count;
      logic           got_empty;
      req_fired <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pred = apply_deq_op(req_tdata[2:0], req_tdata[34:3]);
            expected_words.insert(expected_words.size(), pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_value  = rsp_tdata[31:0];
            got_status = rsp_tdata[33:32];
            got_count  = rsp_tdata[42:34];
            got_empty  = rsp_tdata[43];
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want = expected_words[0];
               expected_words.delete(0);
               if (got_value !== want.value) begin
                  $display("%0t: out_value expected %h got %h", $time, want.value, got_value);
                  error_count = error_count + 1;
               end
               if (got_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, got_status);
                  error_count = error_count + 1;
               end
               if (got_count !== want.count) begin
                  $display("%0t: entry_count expected %0d got %0d", $time, want.count,
                           got_count);
                  error_count = error_count + 1;
               end
               if (got_empty !== want.empty) begin
                  $display("%0t: is_empty expected %0d got %0d", $time, want.empty, got_empty);
                  error_count = error_count + 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic add_op(input logic [2:0] mode, input logic [31:0] value);
      deq_op_type op;
      op.mode  = mode;
      op.value = value;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic set_idling(input int sel);
      case (sel % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
         default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
   endtask

   task automatic wait_sent();
      while (pending_ops.size() != 0) @(posedge clock);
   endtask

   // mix given in percent; what is left over goes to unused modes
   task automatic run_phase(input int n, input int push_pct, input int pop_pct,
                            input int peek_pct);
      int          left;
      int          r;
      logic [2:0]  mode;
      left = n;
      while (left > 0) begin
         set_idling(chunk_no);
         for (int i = 0; i < CHUNK_ITEMS && left > 0; i++) begin
            r = $urandom_range(99);
            if (r < push_pct)
               mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else if (r < push_pct + pop_pct)
               mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
            else if (r < push_pct + pop_pct + peek_pct)
               mode = $urandom_range(1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT;
            else
               mode = $urandom_range(1) ? MODE_UNUSED_7 : MODE_UNUSED_6;
            add_op(mode, $urandom);
            left = left - 1;
         end
         wait_sent();
         chunk_no = chunk_no + 1;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty errors, unused modes, wrap of the front pointer, field extremes
      set_idling(0);
      add_op(MODE_POP_FRONT,  32'h0000_0000);
      add_op(MODE_POP_BACK,   32'hFFFF_FFFF);
      add_op(MODE_PEEK_FRONT, 32'h0000_0000);
      add_op(MODE_PEEK_BACK,  32'hFFFF_FFFF);
      add_op(MODE_UNUSED_6,   32'h1234_5678);
      add_op(MODE_UNUSED_7,   32'hFFFF_FFFF);
      add_op(MODE_PUSH_FRONT, 32'h0000_0000);
      add_op(MODE_PUSH_BACK,  32'hFFFF_FFFF);
      add_op(MODE_PEEK_FRONT, 32'h0000_0000);
      add_op(MODE_PEEK_BACK,  32'h0000_0000);
      add_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
      add_op(MODE_PUSH_BACK,  32'h5555_5555);
      add_op(MODE_UNUSED_7,   32'h0000_0000);
      add_op(MODE_POP_BACK,   32'h0000_0000);
      add_op(MODE_POP_FRONT,  32'h0000_0000);
      add_op(MODE_PEEK_FRONT, 32'h0000_0000);
      add_op(MODE_PEEK_BACK,  32'h0000_0000);
      add_op(MODE_POP_FRONT,  32'h0000_0000);
      add_op(MODE_POP_BACK,   32'h0000_0000);
      add_op(MODE_POP_FRONT,  32'h0000_0000);
      add_op(MODE_PUSH_BACK,  32'h8000_0000);
      add_op(MODE_PUSH_FRONT, 32'h0000_0001);
      add_op(MODE_POP_FRONT,  32'h0000_0000);
      add_op(MODE_POP_BACK,   32'h0000_0000);
      add_op(MODE_PEEK_BACK,  32'h0000_0000);
      wait_sent();
      chunk_no = 1;

      run_phase(90, 45, 35, 16);
      // sink holds off while the fill starts so the response path backs up
      hold_trigger = ~hold_trigger;
      run_phase(280, 96, 1, 1);
      run_phase(330, 5, 90, 3);
      run_phase(30, 45, 35, 16);

      // wait until the last word is accepted and every result has come back
      while (pending_ops.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
